>>> rtl/core/scti_pkg.sv
// ============================================================================
// scti_pkg
// Shared constants, types and the sine table builder for the table-based
// sine/cosine interpolator.
// ============================================================================
package scti_pkg;

    // Field widths and fixed-point formats
    localparam int ANGLE_W          = 24;
    localparam int VALUE_W          = 16;
    localparam int ANGLE_FRAC_BITS  = 8;
    localparam int RESULT_FRAC_BITS = 15;
    localparam int TABLE_ENTRIES    = 361;
    localparam int ROM_FRAC_BITS    = 30;
    localparam int ROM_W            = 32;

    // Function select codes
    localparam logic FUNC_SINE   = 1'b0;
    localparam logic FUNC_COSINE = 1'b1;

    // Angles in whole degrees
    localparam int DEG_FULL          = 360;
    localparam int DEG_QUARTER       = 90;
    localparam int DEG_THREE_QUARTER = 270;

    // Angle reduction: one turn in fixed point, and a whole number of turns
    // added up front so that the dividend is never negative.
    localparam int PERIOD    = DEG_FULL << ANGLE_FRAC_BITS;
    localparam int REM_W     = $clog2(PERIOD);
    localparam int OFFSET    = ((2 ** (ANGLE_W - 1) + PERIOD - 1) / PERIOD) * PERIOD;
    localparam int AOFF_W    = $clog2(2 ** (ANGLE_W - 1) + OFFSET);
    localparam int MAX_QUOT  = (2 ** (ANGLE_W - 1) - 1 + OFFSET) / PERIOD;
    localparam int QUOT_W    = $clog2(MAX_QUOT + 1);

    // Reciprocal of the period, rounded up; exact for every dividend below
    // 2^AOFF_W because the rounding error times the dividend stays below
    // 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = AOFF_W + REM_W;
    localparam longint unsigned RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + 64'(PERIOD) - 64'd1) / 64'(PERIOD);
    localparam int MULT_W = $clog2(RECIP_MULT + 64'd1);

    // Table addressing
    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int IDX_W  = REM_W - ANGLE_FRAC_BITS;

    // Interpolation and rounding
    localparam int DIFF_W      = ROM_W + 1;
    localparam int PROD_W      = DIFF_W + ANGLE_FRAC_BITS + 1;
    localparam int ACC_W       = PROD_W + 1;
    localparam int ROUND_SHIFT = ROM_FRAC_BITS + ANGLE_FRAC_BITS - RESULT_FRAC_BITS;
    localparam int SAT_LIM     = (RESULT_FRAC_BITS >= 15) ? 32767 :
                                 (2 ** RESULT_FRAC_BITS) - 1;

    // Pipeline stages
    localparam int NUM_STAGES = 6;
    localparam int STG_IN     = 0;
    localparam int STG_QUOT   = 1;
    localparam int STG_REM    = 2;
    localparam int STG_ROM    = 3;
    localparam int STG_PROD   = 4;
    localparam int STG_OUT    = 5;

    typedef logic signed [ROM_W-1:0]             rom_word_t;
    typedef logic [TABLE_ENTRIES-1:0][ROM_W-1:0] rom_image_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] full;
    } pipe_ctrl_t;

    localparam longint unsigned Q62_ONE = 64'h4000_0000_0000_0000;
    localparam longint unsigned LO_MASK = 64'h0000_0000_FFFF_FFFF;

    // Restoring long division; it only runs while the table is built.
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned quo, part;
        quo  = 64'd0;
        part = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[62:0], num[b]};
            if (part >= den) begin
                part   = part - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // (a * b) >> 62 built from 32-bit halves
    function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
        longint unsigned ah, al, bh, bl, lo, m1, m2, hi, t, lo64, hi64;
        ah   = a >> 32;
        al   = a & LO_MASK;
        bh   = b >> 32;
        bl   = b & LO_MASK;
        lo   = al * bl;
        m1   = ah * bl;
        m2   = al * bh;
        hi   = ah * bh;
        t    = (lo >> 32) + (m1 & LO_MASK) + (m2 & LO_MASK);
        lo64 = (t << 32) | (lo & LO_MASK);
        hi64 = hi + (m1 >> 32) + (m2 >> 32) + (t >> 32);
        return (hi64 << 2) | (lo64 >> 62);
    endfunction

    // atan(1/n) in Q62 by its alternating series
    function automatic longint unsigned atan_inv_q62(longint unsigned n);
        longint unsigned p, sum, n2, k;
        bit              neg;
        p   = udiv64(Q62_ONE, n);
        sum = p;
        n2  = n * n;
        k   = 64'd1;
        neg = 1'b1;
        p   = udiv64(p, n2);
        while (p != 64'd0) begin
            if (neg)
                sum = sum - udiv64(p, 64'd2 * k + 64'd1);
            else
                sum = sum + udiv64(p, 64'd2 * k + 64'd1);
            neg = !neg;
            k   = k + 64'd1;
            p   = udiv64(p, n2);
        end
        return sum;
    endfunction

    // sin(x) in Q62 on the first quadrant by its Taylor series
    function automatic longint unsigned sin_q62(longint unsigned x);
        longint unsigned x2, term, sum, n;
        bit              neg;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        neg  = 1'b1;
        for (n = 64'd3; n <= 64'd31; n = n + 64'd2) begin
            term = udiv64(mul_q62(term, x2), (n - 64'd1) * n);
            if (neg)
                sum = sum - term;
            else
                sum = sum + term;
            neg = !neg;
        end
        return sum;
    endfunction

    // One-degree sine table in Q2.30, closed by entry 360 = entry 0.
    function automatic rom_image_t build_sin_table();
        rom_image_t      img;
        longint unsigned one_deg, mag;
        longint          v;
        int              k, q, m, j;
        img     = '0;
        one_deg = (64'd4 * atan_inv_q62(64'd5) - atan_inv_q62(64'd239)) / 64'd45;
        for (k = 0; k < DEG_FULL; k++) begin
            q   = k / DEG_QUARTER;
            m   = k % DEG_QUARTER;
            j   = (q % 2 == 1) ? (DEG_QUARTER - m) : m;
            mag = sin_q62(one_deg * 64'(j));
            v   = longint'((mag + (64'd1 << 31)) >> 32);
            img[k] = ROM_W'((q >= 2) ? -v : v);
        end
        img[DEG_FULL] = img[0];
        return img;
    endfunction

endpackage

>>> rtl/core/scti_ifs.sv
// ============================================================================
// scti_ifs
// Valid/ready channels for angle samples and interpolated results.
// ============================================================================
interface scti_sample_if;
    import scti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;
    logic                      func;

    modport source (output valid, angle, func, input ready);
    modport sink   (input valid, angle, func, output ready);
endinterface

interface scti_result_if;
    import scti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

>>> rtl/core/scti_reduce.sv
// ============================================================================
// scti_reduce
// Three-stage floored reduction of the angle modulo one turn, using a
// reciprocal multiply in place of a divider.
// ============================================================================
module scti_reduce (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  scti_pkg::pipe_ctrl_t                   ctrl,
    input  logic signed [scti_pkg::ANGLE_W-1:0]    angle,
    input  logic                                   func,
    output logic [scti_pkg::REM_W-1:0]             rem,
    output logic                                   rem_func
);
    import scti_pkg::*;

    logic [AOFF_W-1:0]        aoff_next;
    logic [AOFF_W-1:0]        aoff_reg;
    logic                     func_s1_reg;

    logic [AOFF_W+MULT_W-1:0] recip_prod;
    logic [QUOT_W-1:0]        quot_next;
    logic [QUOT_W-1:0]        quot_reg;
    logic [AOFF_W-1:0]        aoff_s2_reg;
    logic                     func_s2_reg;

    logic [AOFF_W-1:0]        rem_full;
    logic [REM_W-1:0]         rem_next;
    logic [REM_W-1:0]         rem_reg;
    logic                     func_s3_reg;

    // Whole turns are added first so the dividend is always positive.
    assign aoff_next = AOFF_W'(AOFF_W'(angle) + AOFF_W'(OFFSET));

    assign recip_prod = (AOFF_W + MULT_W)'(aoff_reg)
                      * (AOFF_W + MULT_W)'(RECIP_MULT);
    assign quot_next  = recip_prod[RECIP_SHIFT +: QUOT_W];

    assign rem_full = aoff_s2_reg - AOFF_W'(quot_reg * PERIOD);
    assign rem_next = rem_full[REM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[STG_IN])
        begin
            aoff_reg    <= aoff_next;
            func_s1_reg <= func;
        end
        if (ctrl.load[STG_QUOT])
        begin
            quot_reg    <= quot_next;
            aoff_s2_reg <= aoff_reg;
            func_s2_reg <= func_s1_reg;
        end
        if (ctrl.load[STG_REM])
        begin
            rem_reg     <= rem_next;
            func_s3_reg <= func_s2_reg;
        end
    end

    assign rem      = rem_reg;
    assign rem_func = func_s3_reg;

    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.full[STG_REM] |-> rem_reg < REM_W'(PERIOD))
        else $error("reduced angle is not below one turn");

    a_quot_not_over: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.full[STG_QUOT] |-> AOFF_W'(quot_reg * PERIOD) <= aoff_s2_reg)
        else $error("turn count overshoots the offset angle");

endmodule

>>> rtl/core/scti_rom.sv
// ============================================================================
// scti_rom
// One-degree sine table with two synchronous read ports.
// ============================================================================
module scti_rom (
    input  logic                           clk,
    input  logic                           load,
    input  logic [scti_pkg::ADDR_W-1:0]    addr_a,
    input  logic [scti_pkg::ADDR_W-1:0]    addr_b,
    output scti_pkg::rom_word_t            data_a,
    output scti_pkg::rom_word_t            data_b
);
    import scti_pkg::*;

    localparam rom_image_t SIN_TABLE = build_sin_table();

    rom_word_t data_a_reg;
    rom_word_t data_b_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_a_reg <= $signed(SIN_TABLE[addr_a]);
            data_b_reg <= $signed(SIN_TABLE[addr_b]);
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

>>> rtl/core/scti_interp.sv
// ============================================================================
// scti_interp
// Linear interpolation between neighboring table entries, followed by
// rounding half up and symmetric saturation.
// ============================================================================
module scti_interp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  scti_pkg::pipe_ctrl_t                     ctrl,
    input  logic [scti_pkg::ANGLE_FRAC_BITS-1:0]     frac,
    input  scti_pkg::rom_word_t                      data_a,
    input  scti_pkg::rom_word_t                      data_b,
    output logic signed [scti_pkg::VALUE_W-1:0]      value
);
    import scti_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(64'd1 << (ROUND_SHIFT - 1));
    localparam logic signed [ACC_W-1:0]   LIM_ACC = ACC_W'(SAT_LIM);
    localparam logic signed [VALUE_W-1:0] LIM_V   = VALUE_W'(SAT_LIM);

    logic [ANGLE_FRAC_BITS-1:0] frac_reg;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    rom_word_t                  base_reg;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [VALUE_W-1:0]  value_next;
    logic signed [VALUE_W-1:0]  value_reg;

    assign diff      = DIFF_W'(data_b) - DIFF_W'(data_a);
    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, frac_reg}));

    // The floor of a biased value gives rounding half toward plus infinity.
    assign acc = (ACC_W'(base_reg) <<< ANGLE_FRAC_BITS) + ACC_W'(prod_reg);
    assign rnd = (acc + ROUND_HALF) >>> ROUND_SHIFT;

    always_comb
    begin
        if (rnd > LIM_ACC)
            value_next = LIM_V;
        else if (rnd < -LIM_ACC)
            value_next = -LIM_V;
        else
            value_next = rnd[VALUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[STG_ROM])
            frac_reg <= frac;
        if (ctrl.load[STG_PROD])
        begin
            prod_reg <= prod_next;
            base_reg <= data_a;
        end
        if (ctrl.load[STG_OUT])
            value_reg <= value_next;
    end

    assign value = value_reg;

    a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.full[STG_OUT] |-> (value_reg <= LIM_V) && (value_reg >= -LIM_V))
        else $error("result outside the saturation limits");

endmodule

>>> rtl/core/sine_cosine_table_interpolation.sv
// ============================================================================
// sine_cosine_table_interpolation
// Sine or cosine of an angle in degrees by one-degree table lookup with
// linear interpolation between neighboring entries.
// ============================================================================
//  channel   direction   payload                        transfer when
//  sample    in          angle (s24, Q.8 deg), func     valid && ready
//  result    out         value (s16, Q1.15)             valid && ready
//
//  One item per cycle while result.ready stays high. A sample passes the
//  input, quotient, remainder, table, product and output registers in turn.
//  The two neighboring entries come from the two read ports of the sine
//  table in the same cycle, so no port is shared.
//  Reset clears the stage flags only; the table is constant and needs no fill.
//  A stage holds only while the stage after it is full, so bubbles close up
//  and sample.ready falls only when all six stages hold items.
// ============================================================================
module sine_cosine_table_interpolation (
    input  logic          clk,
    input  logic          rst_n,
    scti_sample_if.sink   sample,
    scti_result_if.source result
);
    import scti_pkg::*;

    pipe_ctrl_t             ctrl;
    logic [NUM_STAGES-1:0]  load;
    logic [NUM_STAGES-1:0]  full_next;
    logic [NUM_STAGES-1:0]  full_reg;

    logic [REM_W-1:0]       rem;
    logic                   rem_func;
    logic [ADDR_W-1:0]      idx;
    logic [ANGLE_FRAC_BITS-1:0] frac;
    logic [ADDR_W-1:0]      addr_base;
    logic [ADDR_W-1:0]      addr_next;
    rom_word_t              data_a;
    rom_word_t              data_b;

    always_comb
    begin
        load[STG_OUT] = !full_reg[STG_OUT] || result.ready;
        for (int k = STG_OUT - 1; k >= 0; k--)
            load[k] = !full_reg[k] || load[k + 1];
    end

    always_comb
    begin
        full_next = full_reg;
        if (load[STG_IN])
            full_next[STG_IN] = sample.valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (load[k])
                full_next[k] = full_reg[k - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= '0;
        else
            full_reg <= full_next;
    end

    assign ctrl.load    = load;
    assign ctrl.full    = full_reg;
    assign sample.ready = load[STG_IN];
    assign result.valid = full_reg[STG_OUT];

    scti_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .angle    (sample.angle),
        .func     (sample.func),
        .rem      (rem),
        .rem_func (rem_func)
    );

    // Cosine reads the sine table a quarter turn ahead.
    assign idx  = ADDR_W'(rem[REM_W-1:ANGLE_FRAC_BITS]);
    assign frac = rem[ANGLE_FRAC_BITS-1:0];

    always_comb
    begin
        if (rem_func == FUNC_COSINE)
        begin
            if (idx >= ADDR_W'(DEG_THREE_QUARTER))
                addr_base = idx - ADDR_W'(DEG_THREE_QUARTER);
            else
                addr_base = idx + ADDR_W'(DEG_QUARTER);
        end
        else
        begin
            addr_base = idx;
        end
    end

    assign addr_next = addr_base + ADDR_W'(1);

    scti_rom u_rom (
        .clk    (clk),
        .load   (load[STG_ROM]),
        .addr_a (addr_base),
        .addr_b (addr_next),
        .data_a (data_a),
        .data_b (data_b)
    );

    scti_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .frac   (frac),
        .data_a (data_a),
        .data_b (data_b),
        .value  (result.value)
    );

    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("input stalled although the output stage is empty");

    a_addr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg[STG_REM] |-> addr_base < ADDR_W'(DEG_FULL))
        else $error("table address beyond the last whole degree");

endmodule
